### rtl/lrp_pkg.sv
package lrp_pkg;

   // Field widths of one request beat and one response beat
   localparam int CMD_W    = 3;
   localparam int STATE_W  = 6;
   localparam int SYM_W    = 5;
   localparam int NT_W     = 4;
   localparam int KIND_W   = 2;
   localparam int TGT_W    = 6;
   localparam int LEN_W    = 4;
   localparam int STATUS_W = 3;
   localparam int RED_W    = 8;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   // Default table and stack sizes
   localparam int DEF_STATE_COUNT       = 64;
   localparam int DEF_TERMINAL_COUNT    = 32;
   localparam int DEF_NONTERMINAL_COUNT = 16;
   localparam int DEF_RULE_COUNT        = 64;
   localparam int DEF_STACK_DEPTH       = 64;
   localparam int DEF_MAX_RHS           = 8;

   // Request commands
   localparam logic [CMD_W-1:0] CMD_TOKEN   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WR_ACT  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WR_GOTO = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WR_RULE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_START   = 3'd4;

   // Action kinds
   localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SHIFT  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REDUCE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHIFTED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_ACCEPT  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_REJECT  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FAULT   = 3'd4;

   typedef enum logic [2:0] {
      OP_TOKEN,
      OP_WR_ACT,
      OP_WR_GOTO,
      OP_WR_RULE,
      OP_START,
      OP_NOP
   } op_type;

   // One classified request held in the queue
   typedef struct packed {
      op_type              op;
      logic                in_range;
      logic [STATE_W-1:0]  table_state;
      logic [SYM_W-1:0]    symbol;
      logic [NT_W-1:0]     nonterminal;
      logic [KIND_W-1:0]   action_kind;
      logic [TGT_W-1:0]    target;
      logic [LEN_W-1:0]    rhs_length;
   } item_type;

   // Queue status seen by the engine
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

### rtl/lr_shift_reduce_parser.sv
// Table-driven LR shift-reduce parser.
// Request channel (req_*): one beat per command. tuser carries the command (token,
// write action, write goto, write rule, start); tdata carries the table address
// and entry fields. Response channel (rsp_*): exactly one beat per request, in
// order, with the status in tuser and the reduction count and top state in tdata.
// A two-entry queue decouples request intake from the parse engine.
// Writes, start and finished-parse tokens answer straight from the idle state; a
// token reads its action, and each reduction it triggers adds a rule read, stack
// read, goto read and action read, each a registered memory port in sequence.
// Items run one at a time through the engine; tables and stack are single-port
// reads with registered data.
// Reset: synchronous. After reset the engine sweeps the action and goto tables to
// zero, covering max(STATE_COUNT*TERMINAL_COUNT, STATE_COUNT*NONTERMINAL_COUNT)
// entries; requests queue up to two deep and then wait.
// Rule entries read undefined until written. The stack is empty until a start.
// Stall: a held response keeps rsp_tdata stable; the engine takes no new item
// until the response register frees, and req_tready drops when the queue is full.
module lr_shift_reduce_parser #(
   parameter int STATE_COUNT       = lrp_pkg::DEF_STATE_COUNT,
   parameter int TERMINAL_COUNT    = lrp_pkg::DEF_TERMINAL_COUNT,
   parameter int NONTERMINAL_COUNT = lrp_pkg::DEF_NONTERMINAL_COUNT,
   parameter int RULE_COUNT        = lrp_pkg::DEF_RULE_COUNT,
   parameter int STACK_DEPTH       = lrp_pkg::DEF_STACK_DEPTH,
   parameter int MAX_RHS           = lrp_pkg::DEF_MAX_RHS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // table_state[5:0], symbol[10:6], nonterminal[14:11], action_kind[16:15],
   // target[22:17], rhs_length[26:23], zero [31:27]
   input  logic [lrp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command[2:0]
   input  logic [lrp_pkg::CMD_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // reductions[7:0], top_state[13:8], zero [15:14]
   output logic [lrp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status[2:0]
   output logic [lrp_pkg::STATUS_W-1:0]      rsp_tuser
);

   lrp_pkg::queue_head_type head;
   logic                    pop;

   lrp_front #(
      .STATE_COUNT      (STATE_COUNT),
      .TERMINAL_COUNT   (TERMINAL_COUNT),
      .NONTERMINAL_COUNT(NONTERMINAL_COUNT),
      .RULE_COUNT       (RULE_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .pop       (pop),
      .head      (head)
   );

   lrp_engine #(
      .STATE_COUNT      (STATE_COUNT),
      .TERMINAL_COUNT   (TERMINAL_COUNT),
      .NONTERMINAL_COUNT(NONTERMINAL_COUNT),
      .RULE_COUNT       (RULE_COUNT),
      .STACK_DEPTH      (STACK_DEPTH),
      .MAX_RHS          (MAX_RHS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // Engine pops only an entry that the queue actually holds
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("engine popped an empty queue");

   // Status stays within the defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= lrp_pkg::STATUS_FAULT))
      else $error("undefined response status");

   // Writes and starts report no reductions
   a_done_no_red: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == lrp_pkg::STATUS_DONE) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("reductions reported on a write or start");

   // A new pop waits for a free response slot
   a_pop_slot: assert property (@(posedge clock) disable iff (reset)
      (pop && rsp_tvalid) |-> rsp_tready)
      else $error("item taken while response slot is held");

endmodule

### rtl/lrp_front.sv
module lrp_front #(
   parameter int STATE_COUNT       = lrp_pkg::DEF_STATE_COUNT,
   parameter int TERMINAL_COUNT    = lrp_pkg::DEF_TERMINAL_COUNT,
   parameter int NONTERMINAL_COUNT = lrp_pkg::DEF_NONTERMINAL_COUNT,
   parameter int RULE_COUNT        = lrp_pkg::DEF_RULE_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lrp_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [lrp_pkg::CMD_W-1:0]         req_tuser,
   input  logic                              pop,
   output lrp_pkg::queue_head_type           head
);

   lrp_pkg::item_type cls;
   lrp_pkg::item_type q_ff [2];
   logic              rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;

   // Unpack and classify the incoming beat
   always_comb begin
      cls.table_state = req_tdata[5:0];
      cls.symbol      = req_tdata[10:6];
      cls.nonterminal = req_tdata[14:11];
      cls.action_kind = req_tdata[16:15];
      cls.target      = req_tdata[22:17];
      cls.rhs_length  = req_tdata[26:23];
      cls.in_range    = 1'b0;
      case (req_tuser)
         lrp_pkg::CMD_TOKEN: begin
            cls.op = lrp_pkg::OP_TOKEN;
         end
         lrp_pkg::CMD_WR_ACT: begin
            cls.op       = lrp_pkg::OP_WR_ACT;
            cls.in_range = (int'(cls.table_state) < STATE_COUNT)
                        && (int'(cls.symbol) < TERMINAL_COUNT);
         end
         lrp_pkg::CMD_WR_GOTO: begin
            cls.op       = lrp_pkg::OP_WR_GOTO;
            cls.in_range = (int'(cls.table_state) < STATE_COUNT)
                        && (int'(cls.nonterminal) < NONTERMINAL_COUNT);
         end
         lrp_pkg::CMD_WR_RULE: begin
            cls.op       = lrp_pkg::OP_WR_RULE;
            cls.in_range = int'(cls.target) < RULE_COUNT;
         end
         lrp_pkg::CMD_START: begin
            cls.op = lrp_pkg::OP_START;
         end
         default: begin
            cls.op = lrp_pkg::OP_NOP;
         end
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_ff[rd_ff];

   always_comb begin
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule

### rtl/lrp_engine.sv
module lrp_engine #(
   parameter int STATE_COUNT       = lrp_pkg::DEF_STATE_COUNT,
   parameter int TERMINAL_COUNT    = lrp_pkg::DEF_TERMINAL_COUNT,
   parameter int NONTERMINAL_COUNT = lrp_pkg::DEF_NONTERMINAL_COUNT,
   parameter int RULE_COUNT        = lrp_pkg::DEF_RULE_COUNT,
   parameter int STACK_DEPTH       = lrp_pkg::DEF_STACK_DEPTH,
   parameter int MAX_RHS           = lrp_pkg::DEF_MAX_RHS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lrp_pkg::queue_head_type           head,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lrp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [lrp_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int ACT_DEPTH  = STATE_COUNT * TERMINAL_COUNT;
   localparam int GOTO_DEPTH = STATE_COUNT * NONTERMINAL_COUNT;
   localparam int AAW = $clog2(ACT_DEPTH);
   localparam int GAW = (GOTO_DEPTH > 1) ? $clog2(GOTO_DEPTH) : 1;
   localparam int RAW = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int CLEAR_LEN = (ACT_DEPTH > GOTO_DEPTH) ? ACT_DEPTH : GOTO_DEPTH;
   localparam int CLW = $clog2(CLEAR_LEN);
   localparam int ACT_W  = lrp_pkg::KIND_W + lrp_pkg::TGT_W;
   localparam int RULE_W = lrp_pkg::NT_W + lrp_pkg::LEN_W;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_ACT, ST_RULE, ST_BELOW, ST_GOTO
   } state_type;

   typedef enum logic [1:0] {
      OC_RUNNING, OC_ACCEPT, OC_REJECT, OC_FAULT
   } outcome_type;

   // Table and stack memories
   logic [ACT_W-1:0]                act_mem  [ACT_DEPTH];
   logic [lrp_pkg::TGT_W-1:0]       goto_mem [GOTO_DEPTH];
   logic [RULE_W-1:0]               rule_mem [RULE_COUNT];
   logic [lrp_pkg::STATE_W-1:0]     stk_mem  [STACK_DEPTH];

   logic                            act_we, goto_we, rule_we, stk_we;
   logic [AAW-1:0]                  act_wa, act_ra;
   logic [GAW-1:0]                  goto_wa, goto_ra;
   logic [RAW-1:0]                  rule_wa, rule_ra;
   logic [SAW-1:0]                  stk_wa, stk_ra;
   logic [ACT_W-1:0]                act_wd, act_rd_ff;
   logic [lrp_pkg::TGT_W-1:0]       goto_wd, goto_rd_ff;
   logic [RULE_W-1:0]               rule_wd, rule_rd_ff;
   logic [lrp_pkg::STATE_W-1:0]     stk_wd, stk_rd_ff;

   state_type                       state_ff, state_in;
   outcome_type                     oc_ff, oc_in;
   logic [CLW-1:0]                  clr_ff, clr_in;
   logic [SPW-1:0]                  sp_ff, sp_in;
   logic [lrp_pkg::STATE_W-1:0]     top_ff, top_in;
   logic [lrp_pkg::RED_W-1:0]       red_ff, red_in;
   logic [lrp_pkg::SYM_W-1:0]       sym_ff, sym_in;
   logic [lrp_pkg::NT_W-1:0]        lhs_ff, lhs_in;
   logic                            aok_ff, aok_in, gok_ff, gok_in;
   logic                            out_valid_ff, out_valid_in;
   logic [lrp_pkg::STATUS_W-1:0]    out_status_ff, out_status_in;
   logic [lrp_pkg::RED_W-1:0]       out_red_ff, out_red_in;
   logic [lrp_pkg::STATE_W-1:0]     out_top_ff, out_top_in;

   logic [lrp_pkg::KIND_W-1:0]      a_kind;
   logic [lrp_pkg::TGT_W-1:0]       a_tgt;
   logic [lrp_pkg::NT_W-1:0]        r_lhs;
   logic [lrp_pkg::LEN_W-1:0]       r_len;
   logic [SPW-1:0]                  sp_pop;
   logic [lrp_pkg::STATE_W-1:0]     nxt;
   logic                            slot_free;
   lrp_pkg::item_type               it;

   always_ff @(posedge clock) begin
      if (act_we) begin
         act_mem[act_wa] <= act_wd;
      end
      act_rd_ff <= act_mem[act_ra];
   end

   always_ff @(posedge clock) begin
      if (goto_we) begin
         goto_mem[goto_wa] <= goto_wd;
      end
      goto_rd_ff <= goto_mem[goto_ra];
   end

   always_ff @(posedge clock) begin
      if (rule_we) begin
         rule_mem[rule_wa] <= rule_wd;
      end
      rule_rd_ff <= rule_mem[rule_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stk_mem[stk_ra];
   end

   assign it        = head.item;
   assign slot_free = !out_valid_ff || rsp_tready;
   assign a_kind    = act_rd_ff[ACT_W-1 -: lrp_pkg::KIND_W];
   assign a_tgt     = act_rd_ff[lrp_pkg::TGT_W-1:0];
   assign r_lhs     = rule_rd_ff[RULE_W-1 -: lrp_pkg::NT_W];
   assign r_len     = rule_rd_ff[lrp_pkg::LEN_W-1:0];
   assign sp_pop    = sp_ff - SPW'(r_len);
   assign nxt       = gok_ff ? goto_rd_ff : '0;

   always_comb begin
      state_in      = state_ff;
      oc_in         = oc_ff;
      clr_in        = clr_ff;
      sp_in         = sp_ff;
      top_in        = top_ff;
      red_in        = red_ff;
      sym_in        = sym_ff;
      lhs_in        = lhs_ff;
      aok_in        = aok_ff;
      gok_in        = gok_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_red_in    = out_red_ff;
      out_top_in    = out_top_ff;
      pop           = 1'b0;
      act_we        = 1'b0;
      goto_we       = 1'b0;
      rule_we       = 1'b0;
      stk_we        = 1'b0;
      act_wa        = AAW'(int'(it.table_state) * TERMINAL_COUNT + int'(it.symbol));
      act_wd        = {it.action_kind, it.target};
      goto_wa       = GAW'(int'(it.table_state) * NONTERMINAL_COUNT + int'(it.nonterminal));
      goto_wd       = it.target;
      rule_wa       = RAW'(it.target);
      rule_wd       = {it.nonterminal,
                       (int'(it.rhs_length) > MAX_RHS) ? lrp_pkg::LEN_W'(MAX_RHS)
                                                       : it.rhs_length};
      stk_wa        = SAW'(sp_ff);
      stk_wd        = '0;
      act_ra        = AAW'(int'(top_ff) * TERMINAL_COUNT + int'(it.symbol));
      goto_ra       = GAW'(int'(stk_rd_ff) * NONTERMINAL_COUNT + int'(lhs_ff));
      rule_ra       = RAW'(a_tgt);
      stk_ra        = SAW'(sp_pop - SPW'(1));

      case (state_ff)
         ST_CLEAR: begin
            // Sweep both lookup tables to the error / zero entry
            act_wa  = AAW'(clr_ff);
            act_wd  = '0;
            act_we  = int'(clr_ff) < ACT_DEPTH;
            goto_wa = GAW'(clr_ff);
            goto_wd = '0;
            goto_we = int'(clr_ff) < GOTO_DEPTH;
            clr_in  = clr_ff + CLW'(1);
            if (int'(clr_ff) == CLEAR_LEN - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid && slot_free) begin
               pop           = 1'b1;
               out_status_in = lrp_pkg::STATUS_DONE;
               out_red_in    = '0;
               out_top_in    = top_ff;
               red_in        = '0;
               sym_in        = it.symbol;
               case (it.op)
                  lrp_pkg::OP_TOKEN: begin
                     if (oc_ff != OC_RUNNING) begin
                        out_valid_in  = 1'b1;
                        out_status_in = (oc_ff == OC_ACCEPT) ? lrp_pkg::STATUS_ACCEPT :
                                        (oc_ff == OC_REJECT) ? lrp_pkg::STATUS_REJECT :
                                                               lrp_pkg::STATUS_FAULT;
                     end else if (sp_ff == '0) begin
                        oc_in         = OC_FAULT;
                        out_valid_in  = 1'b1;
                        out_status_in = lrp_pkg::STATUS_FAULT;
                     end else begin
                        aok_in   = (int'(top_ff) < STATE_COUNT)
                                && (int'(it.symbol) < TERMINAL_COUNT);
                        state_in = ST_ACT;
                     end
                  end
                  lrp_pkg::OP_WR_ACT: begin
                     act_we       = it.in_range;
                     out_valid_in = 1'b1;
                  end
                  lrp_pkg::OP_WR_GOTO: begin
                     goto_we      = it.in_range;
                     out_valid_in = 1'b1;
                  end
                  lrp_pkg::OP_WR_RULE: begin
                     rule_we      = it.in_range;
                     out_valid_in = 1'b1;
                  end
                  lrp_pkg::OP_START: begin
                     stk_wa       = '0;
                     stk_we       = 1'b1;
                     sp_in        = SPW'(1);
                     top_in       = '0;
                     oc_in        = OC_RUNNING;
                     out_top_in   = '0;
                     out_valid_in = 1'b1;
                  end
                  default: begin
                     out_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ACT: begin
            // Action entry for (top, symbol) is in the read register
            out_red_in = red_ff;
            out_top_in = top_ff;
            if (aok_ff && a_kind == lrp_pkg::KIND_SHIFT) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (sp_ff == SPW'(STACK_DEPTH)) begin
                  oc_in         = OC_FAULT;
                  out_status_in = lrp_pkg::STATUS_FAULT;
               end else begin
                  stk_wd        = a_tgt;
                  stk_we        = 1'b1;
                  sp_in         = sp_ff + SPW'(1);
                  top_in        = a_tgt;
                  out_top_in    = a_tgt;
                  out_status_in = lrp_pkg::STATUS_SHIFTED;
               end
            end else if (aok_ff && a_kind == lrp_pkg::KIND_ACCEPT) begin
               oc_in         = OC_ACCEPT;
               out_valid_in  = 1'b1;
               out_status_in = lrp_pkg::STATUS_ACCEPT;
               state_in      = ST_IDLE;
            end else if (!aok_ff || a_kind == lrp_pkg::KIND_ERROR
                         || int'(a_tgt) >= RULE_COUNT || red_ff == '1) begin
               oc_in         = OC_REJECT;
               out_valid_in  = 1'b1;
               out_status_in = lrp_pkg::STATUS_REJECT;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_RULE;
            end
         end
         ST_RULE: begin
            out_red_in = red_ff;
            out_top_in = top_ff;
            // Fault on underflow, or on an empty rule that would push onto a full stack
            if (SPW'(r_len) >= sp_ff || sp_pop == SPW'(STACK_DEPTH)) begin
               oc_in         = OC_FAULT;
               out_valid_in  = 1'b1;
               out_status_in = lrp_pkg::STATUS_FAULT;
               state_in      = ST_IDLE;
            end else begin
               // Pop the right side, fetch the uncovered state
               sp_in    = sp_pop;
               lhs_in   = r_lhs;
               state_in = ST_BELOW;
            end
         end
         ST_BELOW: begin
            gok_in   = (int'(stk_rd_ff) < STATE_COUNT)
                    && (int'(lhs_ff) < NONTERMINAL_COUNT);
            state_in = ST_GOTO;
         end
         ST_GOTO: begin
            // Push the goto state and look up the next action
            stk_wd   = nxt;
            stk_we   = 1'b1;
            sp_in    = sp_ff + SPW'(1);
            top_in   = nxt;
            red_in   = red_ff + lrp_pkg::RED_W'(1);
            act_ra   = AAW'(int'(nxt) * TERMINAL_COUNT + int'(sym_ff));
            aok_in   = (int'(nxt) < STATE_COUNT) && (int'(sym_ff) < TERMINAL_COUNT);
            state_in = ST_ACT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         oc_ff        <= OC_RUNNING;
         clr_ff       <= '0;
         sp_ff        <= '0;
         top_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oc_ff        <= oc_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         top_ff       <= top_in;
         out_valid_ff <= out_valid_in;
      end
      red_ff        <= red_in;
      sym_ff        <= sym_in;
      lhs_ff        <= lhs_in;
      aok_ff        <= aok_in;
      gok_ff        <= gok_in;
      out_status_ff <= out_status_in;
      out_red_ff    <= out_red_in;
      out_top_ff    <= out_top_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {2'b00, out_top_ff, out_red_ff};

endmodule
